/* rtl/fdt_pkg.sv */
package fdt_pkg;

  // Magnitude bytes that take part; bits above are ignored.
  localparam int VALUE_BYTES = 16;
  localparam int VALUE_BITS  = 8 * VALUE_BYTES;
  localparam int CNT_W       = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  // 2^128 - 1 has 39 decimal digits.
  localparam int MAX_DIGITS = 39;
  localparam int DIGIT_W    = 4;
  localparam int BCD_BITS   = MAX_DIGITS * DIGIT_W;
  localparam int POS_W      = $clog2(MAX_DIGITS);

  localparam int SP_W = 6;  // point position, 0..38
  localparam int TZ_W = 5;  // trailing zeros, 0..24

  localparam logic signed [6:0] SCALE_MIN = -7'sd24;
  localparam logic signed [6:0] SCALE_MAX = 7'sd38;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_MINUS = 7'h2d;
  localparam logic [6:0] CHAR_POINT = 7'h2e;

  // Classified request: magnitude plus the formatting it needs.
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [SP_W-1:0]       sp;
    logic [TZ_W-1:0]       tz;
    logic                  neg;
  } desc_t;

  // Converted request: packed BCD digits, most significant at the top.
  typedef struct packed {
    logic [BCD_BITS-1:0] bcd;
    logic [SP_W-1:0]     sp;
    logic [TZ_W-1:0]     tz;
    logic                neg;
  } conv_res_t;

  typedef enum logic [4:0] {
    EMIT_IDLE  = 5'b00001,
    EMIT_SIGN  = 5'b00010,
    EMIT_DIGIT = 5'b00100,
    EMIT_TRAIL = 5'b01000,
    EMIT_HOLD  = 5'b10000
  } emit_state_e;

endpackage

/* rtl/fdt_if.sv */
interface fdt_in_if;
  logic              valid;
  logic              ready;
  logic [63:0]       value_low;
  logic [63:0]       value_high;
  logic signed [6:0] scale;
  logic              is_negative;

  modport source (output valid, value_low, value_high, scale, is_negative, input ready);
  modport sink   (input valid, value_low, value_high, scale, is_negative, output ready);
endinterface

interface fdt_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last;

  modport source (output valid, char_code, last, input ready);
  modport sink   (input valid, char_code, last, output ready);
endinterface

/* rtl/fixed_decimal_to_text.sv */
// Fixed-point decimal to ASCII text. Each input transaction carries a
// 128-bit unsigned magnitude (value_high:value_low), a signed decimal scale
// and a sign flag; the block answers with one output transaction per
// character, most significant first, with last set on the final one. Text
// is an optional '-', the digits (zero prints as "0"), a '.' placed scale
// digits from the right with leading zeros added so a digit stands before
// it, or -scale trailing zeros for a negative scale. Scale is clamped to
// -24..38, so a number is at most 64 characters. The binary-to-BCD unit
// shifts one magnitude bit per cycle after a load and takes the next
// number only when the last result has been handed on. Printing a number
// (taking the BCD digits, the sign, the 39 digit positions with leading
// zeros skipped, the trailing zeros and a settle step) runs in parallel
// with converting the next one; a two-entry queue after the input lets
// the source hand over two further numbers while the converter works.

module fixed_decimal_to_text (
  input  logic       clk_i,
  input  logic       rst_ni,
  fdt_in_if.sink     in_i,
  fdt_out_if.source  out_o
);

  // front -> converter
  logic               desc_valid, desc_ready;
  fdt_pkg::desc_t     desc;

  // converter -> emitter
  logic               res_valid, res_ready;
  fdt_pkg::conv_res_t res;

  // Input side: scale clamp, sign/point classification, queue.
  fdt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .desc_valid_o (desc_valid),
    .desc_ready_i (desc_ready),
    .desc_o       (desc)
  );

  // Shift-and-add-3 binary to BCD, one bit per cycle.
  fdt_convert u_convert (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_ready_o (desc_ready),
    .desc_i       (desc),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // Character sequencer with registered output.
  fdt_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_o       (out_o)
  );

endmodule

/* rtl/fdt_front.sv */
module fdt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  fdt_in_if.sink         in_i,
  output logic           desc_valid_o,
  input  logic           desc_ready_i,
  output fdt_pkg::desc_t desc_o
);

  logic signed [6:0] scale_c;
  logic signed [6:0] scale_n;
  fdt_pkg::desc_t    desc_c;

  fdt_pkg::desc_t                    mem_q [fdt_pkg::QUEUE_DEPTH];
  logic [fdt_pkg::QPTR_W-1:0]        wp_q, rp_q;
  logic [fdt_pkg::QCNT_W-1:0]        cnt_q;
  logic                              push, pop;

  // Clamp the scale and split it into point position / trailing zeros.
  always_comb begin
    priority if (in_i.scale < fdt_pkg::SCALE_MIN) begin
      scale_c = fdt_pkg::SCALE_MIN;
    end else if (in_i.scale > fdt_pkg::SCALE_MAX) begin
      scale_c = fdt_pkg::SCALE_MAX;
    end else begin
      scale_c = in_i.scale;
    end
    scale_n      = -scale_c;
    desc_c.value = fdt_pkg::VALUE_BITS'({in_i.value_high, in_i.value_low});
    desc_c.sp    = (scale_c > 7'sd0) ? scale_c[fdt_pkg::SP_W-1:0] : '0;
    desc_c.tz    = (scale_c < 7'sd0) ? scale_n[fdt_pkg::TZ_W-1:0] : '0;
    desc_c.neg   = in_i.is_negative;
  end

  assign in_i.ready   = (cnt_q != fdt_pkg::QCNT_W'(fdt_pkg::QUEUE_DEPTH));
  assign desc_valid_o = (cnt_q != '0);
  assign desc_o       = mem_q[rp_q];
  assign push         = in_i.valid && in_i.ready;
  assign pop          = desc_valid_o && desc_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= desc_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= (wp_q == fdt_pkg::QPTR_W'(fdt_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop) begin
        rp_q <= (rp_q == fdt_pkg::QPTR_W'(fdt_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* rtl/fdt_convert.sv */
module fdt_convert (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               desc_valid_i,
  output logic               desc_ready_o,
  input  fdt_pkg::desc_t     desc_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output fdt_pkg::conv_res_t res_o
);

  logic [fdt_pkg::VALUE_BITS-1:0] bin_q;
  logic [fdt_pkg::BCD_BITS-1:0]   bcd_q;
  logic [fdt_pkg::BCD_BITS-1:0]   bcd_adj;
  logic [fdt_pkg::CNT_W-1:0]      cnt_q;
  logic [fdt_pkg::SP_W-1:0]       sp_q;
  logic [fdt_pkg::TZ_W-1:0]       tz_q;
  logic                           neg_q;
  logic                           busy_q, done_q;
  logic                           load;

  // Add 3 to every digit of 5 or more ahead of the shift.
  always_comb begin
    for (int i = 0; i < fdt_pkg::MAX_DIGITS; i++) begin
      bcd_adj[i*fdt_pkg::DIGIT_W +: fdt_pkg::DIGIT_W] =
        (bcd_q[i*fdt_pkg::DIGIT_W +: fdt_pkg::DIGIT_W] >= 4'd5) ?
        bcd_q[i*fdt_pkg::DIGIT_W +: fdt_pkg::DIGIT_W] + 4'd3 :
        bcd_q[i*fdt_pkg::DIGIT_W +: fdt_pkg::DIGIT_W];
    end
  end

  assign desc_ready_o = !busy_q && (!done_q || res_ready_i);
  assign load         = desc_valid_i && desc_ready_o;
  assign res_valid_o  = done_q;
  assign res_o.bcd    = bcd_q;
  assign res_o.sp     = sp_q;
  assign res_o.tz     = tz_q;
  assign res_o.neg    = neg_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      bin_q <= desc_i.value;
      bcd_q <= '0;
      sp_q  <= desc_i.sp;
      tz_q  <= desc_i.tz;
      neg_q <= desc_i.neg;
    end else if (busy_q) begin
      bin_q <= bin_q << 1;
      bcd_q <= {bcd_adj[fdt_pkg::BCD_BITS-2:0], bin_q[fdt_pkg::VALUE_BITS-1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= fdt_pkg::CNT_W'(fdt_pkg::VALUE_BITS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end else if (done_q && res_ready_i) begin
        done_q <= 1'b0;
      end
    end
  end

endmodule

/* rtl/fdt_emit.sv */
module fdt_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  output logic               res_ready_o,
  input  fdt_pkg::conv_res_t res_i,
  fdt_out_if.source          out_o
);

  fdt_pkg::emit_state_e         state_q, state_d;
  logic [fdt_pkg::BCD_BITS-1:0] bcd_q, bcd_d;
  logic [fdt_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [fdt_pkg::SP_W-1:0]     sp_q, sp_d;
  logic [fdt_pkg::TZ_W-1:0]     tz_q, tz_d;
  logic                         neg_q, neg_d;
  logic                         started_q, started_d;
  logic                         point_q, point_d;
  logic                         ov_q, ov_d;
  logic [6:0]                   oc_q, oc_d;
  logic                         ol_q, ol_d;

  logic [fdt_pkg::DIGIT_W-1:0]  digit;
  logic                         free, print, point_here;

  assign digit = bcd_q[fdt_pkg::BCD_BITS-1 -: fdt_pkg::DIGIT_W];
  assign free  = !ov_q || out_o.ready;
  // A digit prints once a nonzero one is seen, for the units digit, and for
  // every position the point reaches.
  assign print = started_q || (digit != '0) || (pos_q == '0) ||
                 (fdt_pkg::SP_W'(pos_q) <= sp_q);
  assign point_here = (sp_q != '0) && !point_q &&
                      (fdt_pkg::SP_W'(pos_q) + fdt_pkg::SP_W'(1) == sp_q);

  assign res_ready_o     = (state_q == fdt_pkg::EMIT_IDLE);
  assign out_o.valid     = ov_q;
  assign out_o.char_code = oc_q;
  assign out_o.last      = ol_q;

  always_comb begin
    state_d   = state_q;
    bcd_d     = bcd_q;
    pos_d     = pos_q;
    sp_d      = sp_q;
    tz_d      = tz_q;
    neg_d     = neg_q;
    started_d = started_q;
    point_d   = point_q;
    ov_d      = ov_q && !out_o.ready;
    oc_d      = oc_q;
    ol_d      = ol_q;
    unique case (state_q)
      fdt_pkg::EMIT_IDLE: begin
        if (res_valid_i) begin
          bcd_d     = res_i.bcd;
          pos_d     = fdt_pkg::POS_W'(fdt_pkg::MAX_DIGITS - 1);
          sp_d      = res_i.sp;
          tz_d      = res_i.tz;
          neg_d     = res_i.neg;
          started_d = 1'b0;
          point_d   = 1'b0;
          state_d   = res_i.neg ? fdt_pkg::EMIT_SIGN : fdt_pkg::EMIT_DIGIT;
        end
      end
      fdt_pkg::EMIT_SIGN: begin
        if (free) begin
          ov_d    = 1'b1;
          oc_d    = fdt_pkg::CHAR_MINUS;
          ol_d    = 1'b0;
          state_d = fdt_pkg::EMIT_DIGIT;
        end
      end
      fdt_pkg::EMIT_DIGIT: begin
        if (!print) begin
          // leading zero: skip without output
          bcd_d = bcd_q << fdt_pkg::DIGIT_W;
          pos_d = pos_q - 1'b1;
        end else if (point_here) begin
          if (free) begin
            ov_d      = 1'b1;
            oc_d      = fdt_pkg::CHAR_POINT;
            ol_d      = 1'b0;
            point_d   = 1'b1;
            started_d = 1'b1;
          end
        end else if (free) begin
          ov_d      = 1'b1;
          oc_d      = fdt_pkg::CHAR_ZERO + {3'b000, digit};
          started_d = 1'b1;
          bcd_d     = bcd_q << fdt_pkg::DIGIT_W;
          if (pos_q == '0) begin
            ol_d    = (tz_q == '0);
            state_d = (tz_q == '0) ? fdt_pkg::EMIT_HOLD : fdt_pkg::EMIT_TRAIL;
          end else begin
            ol_d  = 1'b0;
            pos_d = pos_q - 1'b1;
          end
        end
      end
      fdt_pkg::EMIT_TRAIL: begin
        if (free) begin
          ov_d = 1'b1;
          oc_d = fdt_pkg::CHAR_ZERO;
          ol_d = (tz_q == fdt_pkg::TZ_W'(1));
          tz_d = tz_q - 1'b1;
          if (tz_q == fdt_pkg::TZ_W'(1)) begin
            state_d = fdt_pkg::EMIT_HOLD;
          end
        end
      end
      fdt_pkg::EMIT_HOLD: begin
        // settle before the next request is taken
        state_d = fdt_pkg::EMIT_IDLE;
      end
      default: state_d = fdt_pkg::EMIT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    pos_q <= pos_d;
    sp_q  <= sp_d;
    tz_q  <= tz_d;
    neg_q <= neg_d;
    oc_q  <= oc_d;
    ol_q  <= ol_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fdt_pkg::EMIT_IDLE;
      started_q <= 1'b0;
      point_q   <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      point_q   <= point_d;
      ov_q      <= ov_d;
    end
  end

endmodule
